// ----- rtl/core/edrp_pkg.sv -----
package edrp_pkg;

   // Default number of fields in one record.
   localparam int FIELD_COUNT_DEFAULT = 4;

   // Result queue depth; two free entries are needed to take a new byte.
   localparam int RSP_QUEUE_DEPTH = 4;

   // Byte values with a fixed meaning.
   localparam logic [7:0] DELIM_RESET = 8'd59;
   localparam logic [7:0] CHAR_BSLASH = 8'd92;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_NUL = 8'd0;

   // Result kinds.
   localparam logic [2:0] KIND_DATA = 3'd0;
   localparam logic [2:0] KIND_FIELD_END = 3'd1;
   localparam logic [2:0] KIND_REC_END = 3'd2;
   localparam logic [2:0] KIND_REC_TEXT_END = 3'd3;
   localparam logic [2:0] KIND_TEXT_END = 3'd4;
   localparam logic [2:0] KIND_ERROR = 3'd5;

   // Error codes.
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_FEW = 2'd2;
   localparam logic [1:0] ERR_MANY = 2'd3;

   // One result word.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_byte;
      logic [2:0] field_index;
      logic [1:0] error_code;
      logic       last;
   } rsp_word_type;

endpackage

// ----- rtl/core/escaped_delimited_record_parser_top.sv -----
// Streaming parser for delimiter-separated records with backslash escapes. Each
// accepted text byte is registered, decoded combinationally against the parser
// state, and its zero, one or two result words are pushed into a four-word
// result queue. A byte is taken every cycle as long as the queue has room for
// two words; a byte that yields two words (a backslash followed by a plain byte
// or a zero) needs the single result port for both words, so the sustained
// rate is one byte per cycle when each byte yields at most one word. Between
// byte accept and its first word on the result port lie the input register
// and the result queue. The delimiter register is written through the csr
// port, which is always ready, and must only be written while idle.
module escaped_delimited_record_parser_top #(
   parameter int FIELD_COUNT = edrp_pkg::FIELD_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_field_index,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_delimiter
);

   localparam int QD = edrp_pkg::RSP_QUEUE_DEPTH;
   localparam int PW = $clog2(QD);
   localparam int CW = $clog2(QD + 1);
   localparam logic [3:0] LAST_IDX = 4'(FIELD_COUNT - 1);

   // Configuration register.
   logic [7:0] delim_ff;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Parser state.
   logic       esc_ff, esc_in;
   logic [2:0] field_ff, field_in;
   logic       has_ff, has_in;
   logic       hold_ff, hold_in;

   // Result queue.
   edrp_pkg::rsp_word_type q_mem_ff [QD];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   logic process;
   logic pop;
   logic [1:0] n_words;
   edrp_pkg::rsp_word_type w0, w1;

   // Plain-byte decode results.
   logic p_valid;
   edrp_pkg::rsp_word_type p_word;
   logic       p_esc, p_has, p_hold;
   logic [2:0] p_field;
   logic       is_delim, last_field;
   logic [7:0] b;

   assign csr_ready = 1'b1;

   // Configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= edrp_pkg::DELIM_RESET;
      end else if (csr_valid) begin
         delim_ff <= csr_delimiter;
      end
   end

   // A registered byte is decoded once the queue can take two words.
   assign process = in_valid_ff && (count_ff <= CW'(QD - 2));
   assign req_stall = in_valid_ff && !process;
   assign in_valid_in = (req_valid && !req_stall) ? 1'b1 : (in_valid_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_in;
      end
   end

   assign b = in_byte_ff;
   assign is_delim = (delim_ff != edrp_pkg::CHAR_NUL) && (b == delim_ff);
   assign last_field = {1'b0, field_ff} >= LAST_IDX;

   // Decode of a byte with no escape pending.
   always_comb begin
      p_valid = 1'b1;
      p_word = '0;
      p_word.field_index = field_ff;
      p_esc = 1'b0;
      p_has = has_ff;
      p_field = field_ff;
      p_hold = 1'b0;
      if (is_delim) begin
         if (!has_ff || last_field) begin
            p_word.kind = edrp_pkg::KIND_ERROR;
            p_word.error_code = !has_ff ? edrp_pkg::ERR_EMPTY : edrp_pkg::ERR_MANY;
            p_field = 3'd0;
            p_has = 1'b0;
            p_hold = 1'b1;
         end else begin
            p_word.kind = edrp_pkg::KIND_FIELD_END;
            p_field = field_ff + 3'd1;
            p_has = 1'b0;
         end
      end else if (b == edrp_pkg::CHAR_NUL) begin
         p_field = 3'd0;
         p_has = 1'b0;
         if (field_ff == 3'd0 && !has_ff) begin
            p_word.kind = edrp_pkg::KIND_TEXT_END;
         end else if (!has_ff) begin
            p_word.kind = edrp_pkg::KIND_ERROR;
            p_word.error_code = edrp_pkg::ERR_EMPTY;
         end else if (!last_field) begin
            p_word.kind = edrp_pkg::KIND_ERROR;
            p_word.error_code = edrp_pkg::ERR_FEW;
         end else begin
            p_word.kind = edrp_pkg::KIND_REC_TEXT_END;
         end
      end else if (b == edrp_pkg::CHAR_NEWLINE) begin
         p_field = 3'd0;
         p_has = 1'b0;
         if (!has_ff || !last_field) begin
            p_word.kind = edrp_pkg::KIND_ERROR;
            p_word.error_code = !has_ff ? edrp_pkg::ERR_EMPTY : edrp_pkg::ERR_FEW;
            p_hold = 1'b1;
         end else begin
            p_word.kind = edrp_pkg::KIND_REC_END;
         end
      end else if (b == edrp_pkg::CHAR_BSLASH) begin
         p_valid = 1'b0;
         p_esc = 1'b1;
         p_has = 1'b1;
      end else begin
         p_word.kind = edrp_pkg::KIND_DATA;
         p_word.data_byte = b;
         p_has = 1'b1;
      end
   end

   // Full byte decode: error hold, pending escape, then the plain path.
   always_comb begin
      n_words = 2'd0;
      w0 = '0;
      w1 = '0;
      esc_in = esc_ff;
      field_in = field_ff;
      has_in = has_ff;
      hold_in = hold_ff;
      if (process) begin
         if (hold_ff) begin
            if (b == edrp_pkg::CHAR_NUL) begin
               hold_in = 1'b0;
            end
         end else if (esc_ff) begin
            esc_in = 1'b0;
            w0.kind = edrp_pkg::KIND_DATA;
            w0.field_index = field_ff;
            if (b == edrp_pkg::CHAR_BSLASH || b == edrp_pkg::CHAR_NEWLINE || is_delim) begin
               w0.data_byte = b;
               w0.last = 1'b1;
               n_words = 2'd1;
            end else begin
               w0.data_byte = edrp_pkg::CHAR_BSLASH;
               esc_in = p_esc;
               field_in = p_field;
               has_in = p_has;
               hold_in = p_hold;
               if (p_valid) begin
                  w1 = p_word;
                  w1.last = 1'b1;
                  n_words = 2'd2;
               end else begin
                  w0.last = 1'b1;
                  n_words = 2'd1;
               end
            end
         end else begin
            esc_in = p_esc;
            field_in = p_field;
            has_in = p_has;
            hold_in = p_hold;
            if (p_valid) begin
               w0 = p_word;
               w0.last = 1'b1;
               n_words = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
         field_ff <= 3'd0;
         has_ff <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         esc_ff <= esc_in;
         field_ff <= field_in;
         has_ff <= has_in;
         hold_ff <= hold_in;
      end
   end

   // Result queue: up to two writes and one read per cycle.
   assign pop = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (n_words != 2'd0) begin
         q_mem_ff[wr_ptr_ff] <= w0;
      end
      if (n_words == 2'd2) begin
         q_mem_ff[wr_ptr_ff + PW'(1)] <= w1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PW'(n_words);
         rd_ptr_ff <= rd_ptr_ff + PW'(pop);
         count_ff <= count_ff + CW'(n_words) - CW'(pop);
      end
   end

   // Result port driven from the queue head.
   assign rsp_valid = count_ff != '0;
   assign rsp_kind = q_mem_ff[rd_ptr_ff].kind;
   assign rsp_data_byte = q_mem_ff[rd_ptr_ff].data_byte;
   assign rsp_field_index = q_mem_ff[rd_ptr_ff].field_index;
   assign rsp_error_code = q_mem_ff[rd_ptr_ff].error_code;
   assign rsp_last = q_mem_ff[rd_ptr_ff].last;

endmodule

// ----- rtl/core/edrp_checker.sv -----
module edrp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [2:0] rsp_field_index,
   input logic [1:0] rsp_error_code,
   input logic       rsp_last
);

   // An error word, and only an error word, carries a nonzero code.
   a_err_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == edrp_pkg::KIND_ERROR) == (rsp_error_code != edrp_pkg::ERR_NONE)))
      else $error("error code does not match result kind");

   // Only data words carry a data byte.
   a_data_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != edrp_pkg::KIND_DATA) |-> (rsp_data_byte == 8'd0))
      else $error("event word carries a data byte");

   // A clean text end is always field zero and the final word of its byte.
   a_text_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == edrp_pkg::KIND_TEXT_END)
         |-> (rsp_field_index == 3'd0 && rsp_last))
      else $error("text end word malformed");

   // Every event other than a data byte closes the work of its input byte.
   a_event_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != edrp_pkg::KIND_DATA) |-> rsp_last)
      else $error("event word is not last");

   // A stalled result word holds.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte)))
      else $error("stalled result word changed");

endmodule

bind escaped_delimited_record_parser_top edrp_checker u_edrp_checker (.*);

// ----- tb/escaped_delimited_record_parser_top_tb.sv -----
`timescale 1ns / 100ps

module escaped_delimited_record_parser_top_tb;

   localparam int FIELDS = edrp_pkg::FIELD_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [2:0] rsp_field_index;
   logic [1:0] rsp_error_code;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_delimiter = 8'h00;

   // Text bytes waiting to be sent and result words waiting to be seen.
   logic [7:0]             pending_bytes[$];
   edrp_pkg::rsp_word_type expected_words[$];

   // Parser state as the testbench tracks it.
   logic [7:0] delim_reg = edrp_pkg::DELIM_RESET;
   logic       esc_pending = 1'b0;
   logic [2:0] field_no = 3'd0;
   logic       has_bytes = 1'b0;
   logic       err_hold = 1'b0;

   // Delimiter that the stimulus generator shapes records around.
   logic [7:0] phase_delim = edrp_pkg::DELIM_RESET;

   int failures = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   int words_checked = 0;
   int error_words = 0;
   int record_ends = 0;
   int delim_writes = 0;
   int send_gap = 0;
   int send_calm = 0;
   int stall_left = 0;
   int stall_calm = 0;

   escaped_delimited_record_parser_top #(
      .FIELD_COUNT(FIELDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_field_index(rsp_field_index),
      .rsp_error_code(rsp_error_code),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_delimiter(csr_delimiter)
   );

   always #6 clock = ~clock;

   // Idle lengths: mostly none or short, a few long, and now and then a calm stretch.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic string show_word(edrp_pkg::rsp_word_type w);
      return $sformatf("kind=%0d data=0x%02h field=%0d err=%0d last=%0b",
                       w.kind, w.data_byte, w.field_index, w.error_code, w.last);
   endfunction

   task automatic log_failure(string what);
      failures++;
      if (failures <= REPORT_MAX) $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Parser prediction
   // ---------------------------------------------------------------------

   function automatic void push_word(logic [2:0] kind, logic [7:0] data,
                                     logic [2:0] index, logic [1:0] code);
      edrp_pkg::rsp_word_type w;
      w.kind = kind;
      w.data_byte = data;
      w.field_index = index;
      w.error_code = code;
      w.last = 1'b0;
      expected_words.push_back(w);
   endfunction

   function automatic void clear_record();
      field_no = 3'd0;
      has_bytes = 1'b0;
      esc_pending = 1'b0;
   endfunction

   // An error drops the record; unless it came at a zero, bytes are skipped up to the next zero.
   function automatic void flag_error(logic [1:0] code, bit at_zero);
      push_word(edrp_pkg::KIND_ERROR, 8'h00, field_no, code);
      clear_record();
      err_hold = !at_zero;
   endfunction

   function automatic bit splits_field(logic [7:0] b);
      return delim_reg != edrp_pkg::CHAR_NUL && b == delim_reg;
   endfunction

   // A byte seen with no escape pending. The delimiter is checked first.
   function automatic void parse_plain(logic [7:0] b);
      bit last_field;
      last_field = (int'(field_no) + 1) >= FIELDS;
      if (splits_field(b)) begin
         if (!has_bytes) flag_error(edrp_pkg::ERR_EMPTY, 1'b0);
         else if (last_field) flag_error(edrp_pkg::ERR_MANY, 1'b0);
         else begin
            push_word(edrp_pkg::KIND_FIELD_END, 8'h00, field_no, edrp_pkg::ERR_NONE);
            field_no = field_no + 3'd1;
            has_bytes = 1'b0;
         end
      end else if (b == edrp_pkg::CHAR_NUL) begin
         if (field_no == 3'd0 && !has_bytes) begin
            clear_record();
            push_word(edrp_pkg::KIND_TEXT_END, 8'h00, 3'd0, edrp_pkg::ERR_NONE);
         end else if (!has_bytes) flag_error(edrp_pkg::ERR_EMPTY, 1'b1);
         else if (!last_field) flag_error(edrp_pkg::ERR_FEW, 1'b1);
         else begin
            push_word(edrp_pkg::KIND_REC_TEXT_END, 8'h00, field_no, edrp_pkg::ERR_NONE);
            clear_record();
         end
      end else if (b == edrp_pkg::CHAR_NEWLINE) begin
         if (!has_bytes) flag_error(edrp_pkg::ERR_EMPTY, 1'b0);
         else if (!last_field) flag_error(edrp_pkg::ERR_FEW, 1'b0);
         else begin
            push_word(edrp_pkg::KIND_REC_END, 8'h00, field_no, edrp_pkg::ERR_NONE);
            clear_record();
         end
      end else if (b == edrp_pkg::CHAR_BSLASH) begin
         esc_pending = 1'b1;
         has_bytes = 1'b1;
      end else begin
         has_bytes = 1'b1;
         push_word(edrp_pkg::KIND_DATA, b, field_no, edrp_pkg::ERR_NONE);
      end
   endfunction

   // Works out the words that one accepted text byte causes and marks the final one.
   function automatic void parse_byte(logic [7:0] b);
      int words_before;
      words_before = expected_words.size();
      if (err_hold) begin
         if (b == edrp_pkg::CHAR_NUL) err_hold = 1'b0;
         return;
      end
      if (esc_pending) begin
         esc_pending = 1'b0;
         if (b == edrp_pkg::CHAR_BSLASH || b == edrp_pkg::CHAR_NEWLINE || splits_field(b)) begin
            push_word(edrp_pkg::KIND_DATA, b, field_no, edrp_pkg::ERR_NONE);
         end else begin
            // The backslash stands as a literal byte, then the byte is parsed normally.
            push_word(edrp_pkg::KIND_DATA, edrp_pkg::CHAR_BSLASH, field_no, edrp_pkg::ERR_NONE);
            parse_plain(b);
         end
      end else begin
         parse_plain(b);
      end
      if (expected_words.size() > words_before)
         expected_words[expected_words.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == edrp_pkg::CHAR_NEWLINE || c == edrp_pkg::CHAR_BSLASH || c == phase_delim);
      return c;
   endfunction

   // Field content: plain bytes, escaped specials and literal backslashes.
   task automatic add_field_body();
      int tokens;
      int r;
      tokens = $urandom_range(1, 4);
      repeat (tokens) begin
         r = $urandom_range(0, 99);
         if (r < 70 || phase_delim == edrp_pkg::CHAR_BSLASH) begin
            pending_bytes.push_back(plain_char());
         end else if (r < 85) begin
            pending_bytes.push_back(edrp_pkg::CHAR_BSLASH);
            case ($urandom_range(0, 2))
               0: pending_bytes.push_back(edrp_pkg::CHAR_BSLASH);
               1: pending_bytes.push_back(edrp_pkg::CHAR_NEWLINE);
               default: begin
                  pending_bytes.push_back(phase_delim == edrp_pkg::CHAR_NUL ?
                                          edrp_pkg::CHAR_BSLASH : phase_delim);
               end
            endcase
         end else begin
            pending_bytes.push_back(edrp_pkg::CHAR_BSLASH);
            pending_bytes.push_back(plain_char());
         end
      end
   endtask

   // Mostly well-formed records; the rest are bare text ends, short or long records,
   // empty fields and raw noise.
   task automatic add_record();
      int mode;
      int nf;
      int empty_at;
      bit broken;
      mode = $urandom_range(0, 99);
      nf = FIELDS;
      empty_at = -1;
      broken = 1'b1;
      if (mode < 8) begin
         pending_bytes.push_back(edrp_pkg::CHAR_NUL);
         return;
      end
      if (mode >= 82 && mode < 88) begin
         repeat ($urandom_range(1, 12)) pending_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         if (mode >= 88 && mode < 92) nf = $urandom_range(1, FIELDS - 1);
         else if (mode >= 92 && mode < 96) nf = FIELDS + $urandom_range(1, 2);
         else if (mode >= 96) empty_at = $urandom_range(0, FIELDS - 1);
         else broken = 1'b0;
         for (int f = 0; f < nf; f++) begin
            if (f > 0) pending_bytes.push_back(phase_delim);
            if (f != empty_at) add_field_body();
         end
         if (phase_delim != edrp_pkg::CHAR_NEWLINE && $urandom_range(0, 99) < 80) begin
            pending_bytes.push_back(edrp_pkg::CHAR_NEWLINE);
         end else begin
            if ($urandom_range(0, 2) == 0) pending_bytes.push_back(edrp_pkg::CHAR_BSLASH);
            pending_bytes.push_back(edrp_pkg::CHAR_NUL);
         end
      end
      // A zero usually follows a broken record so that parsing resumes.
      if (broken && $urandom_range(0, 3) != 0) pending_bytes.push_back(edrp_pkg::CHAR_NUL);
   endtask

   // Waits until every byte is sent and every word has arrived, then lets the pipe drain.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One phase: set the delimiter while idle, then send random records around it.
   task automatic run_phase(logic [7:0] delim_value, int byte_target);
      @(posedge clock);
      csr_delimiter <= delim_value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      delim_reg = delim_value;
      phase_delim = delim_value;
      delim_writes++;
      @(negedge clock);
      while (pending_bytes.size() < byte_target) add_record();
      pending_bytes.push_back(edrp_pkg::CHAR_NUL);
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed text under the reset delimiter: a clean text end, a full record with
      // every escape form ending in a backslash before zero, then a delimiter in the
      // last field followed by the zero that clears the error.
      pending_bytes = '{edrp_pkg::CHAR_NUL,
                        8'hFF, edrp_pkg::CHAR_BSLASH, edrp_pkg::DELIM_RESET,
                        edrp_pkg::DELIM_RESET,
                        edrp_pkg::CHAR_BSLASH, edrp_pkg::CHAR_BSLASH, edrp_pkg::DELIM_RESET,
                        edrp_pkg::CHAR_BSLASH, edrp_pkg::CHAR_NEWLINE, edrp_pkg::DELIM_RESET,
                        8'h01, edrp_pkg::CHAR_BSLASH, 8'h41,
                        edrp_pkg::CHAR_BSLASH, edrp_pkg::CHAR_NUL,
                        8'h70, edrp_pkg::DELIM_RESET, 8'h71, edrp_pkg::DELIM_RESET,
                        8'h72, edrp_pkg::DELIM_RESET, 8'h73, edrp_pkg::DELIM_RESET,
                        edrp_pkg::CHAR_NUL};
      wait_idle();

      run_phase(8'h2C, 110);
      run_phase(edrp_pkg::CHAR_NUL, 50);
      run_phase(edrp_pkg::CHAR_BSLASH, 80);
      run_phase(edrp_pkg::CHAR_NEWLINE, 80);
      run_phase(8'hFF, 80);
      run_phase(edrp_pkg::DELIM_RESET, 160);

      if (expected_words.size() != 0)
         log_failure($sformatf("%0d expected words never arrived", expected_words.size()));
      $display("Run covered %0d text bytes under %0d delimiter writes and checked %0d words.",
               bytes_sent, delim_writes, words_checked);
      $display("Among the words were %0d record ends and %0d errors; %0d failures counted.",
               record_ends, error_words, failures);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Byte driver: holds a stalled word, otherwise sends the next byte after its gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_byte_in);
            bytes_sent++;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_byte_in <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            send_gap = pick_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: checks each accepted word against the oldest expectation.
   always @(posedge clock) begin
      edrp_pkg::rsp_word_type got;
      edrp_pkg::rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_kind;
            got.data_byte = rsp_data_byte;
            got.field_index = rsp_field_index;
            got.error_code = rsp_error_code;
            got.last = rsp_last;
            words_checked++;
            if (got.kind == edrp_pkg::KIND_ERROR) error_words++;
            if (got.kind == edrp_pkg::KIND_REC_END || got.kind == edrp_pkg::KIND_REC_TEXT_END)
               record_ends++;
            if (expected_words.size() == 0) begin
               log_failure({"unexpected word: ", show_word(got)});
            end else begin
               want = expected_words.pop_front();
               if (got !== want)
                  log_failure({"expected ", show_word(want), " got ", show_word(got)});
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap(stall_calm);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding.",
                  cycle_count, expected_words.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
rtl/core/edrp_pkg.sv
rtl/core/escaped_delimited_record_parser_top.sv
rtl/core/edrp_checker.sv
tb/escaped_delimited_record_parser_top_tb.sv
